>>> design/cdsd_pkg.sv
// Shared widths, default parameter values and spring constants for the smoothing core.
package cdsd_pkg;

    // Fixed field widths
    localparam int ST_W = 24;               // smooth_time register
    localparam int DT_W = 24;               // time_step input

    // Parameter defaults
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // omega = OMEGA_NUM / smooth_time
    localparam int OMEGA_NUM = 2;

    // Polynomial coefficients as ratios, rounded to FRAC_BITS at elaboration
    localparam int K048_NUM  = 48;
    localparam int K048_DEN  = 100;
    localparam int K0235_NUM = 235;
    localparam int K0235_DEN = 1000;

    // Replacement for a zero smoothing time: 1 / TINY_DEN seconds
    localparam int TINY_DEN = 1000;

endpackage

>>> design/critically_damped_smoothing_3d_core.sv
// Critically damped smoothing core: 3-axis spring step on a shared multiplier and divider.
//
//  Channel | Direction | Handshake                     | Payload
//  --------+-----------+-------------------------------+---------------------------------------
//  in      | sink      | in_valid / in_stall           | time_step, has_target, pos_*, target_*
//  out     | source    | out_valid / out_stall         | new_x, new_y, new_z, updated
//  cfg     | sink      | cfg_wr_en (no wait)           | cfg_wr_data (smooth_time)
//
// Sequence: a pass-through transaction (no target or dt <= 0) skips the arithmetic. An updating
// transaction runs through the single multiplier (20 products), the one-bit-per-cycle divider
// (two quotients) and 18 saturating adds on the shared adder.
// Reset: rst_n clears velocity, the sequencer and the output valid; smooth_time returns to 1.0 s.
// Stalls: in_stall is high whenever the sequencer is busy. A finished result waits in the
// output register while the next transaction is already accepted and worked on.
module critically_damped_smoothing_3d_core
    import cdsd_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_wr_en,
    input  logic [ST_W-1:0]               cfg_wr_data,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [DT_W-1:0]        time_step,
    input  logic                          has_target,
    input  logic signed [VALUE_WIDTH-1:0] pos_x,
    input  logic signed [VALUE_WIDTH-1:0] pos_y,
    input  logic signed [VALUE_WIDTH-1:0] pos_z,
    input  logic signed [VALUE_WIDTH-1:0] target_x,
    input  logic signed [VALUE_WIDTH-1:0] target_y,
    input  logic signed [VALUE_WIDTH-1:0] target_z,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [VALUE_WIDTH-1:0] new_x,
    output logic signed [VALUE_WIDTH-1:0] new_y,
    output logic signed [VALUE_WIDTH-1:0] new_z,
    output logic                          updated
);

    // ------------------------------------------------------------------
    // Derived widths
    // ------------------------------------------------------------------
    localparam int VW  = VALUE_WIDTH;
    // multiplier operand width: values and the time step
    localparam int OPW = (VW > DT_W) ? VW : DT_W;
    localparam int HW  = (OPW + 1) / 2;         // half of the b operand per pass
    localparam int BW  = 2 * HW;
    localparam int PPW = OPW + HW;              // one partial product
    localparam int PW  = OPW + BW + 1;          // full product plus rounding carry
    // divider: dividend/quotient and divisor widths
    localparam int DVD_A = 2 * FRAC_BITS + 3;
    localparam int DVD_B = (VW + 1 > ST_W + 1) ? VW + 1 : ST_W + 1;
    localparam int DVD_W = (DVD_A > DVD_B) ? DVD_A : DVD_B;
    localparam int DSR_W = (VW > ST_W) ? VW : ST_W;
    localparam int CW    = $clog2(DVD_W + 1);

    // ------------------------------------------------------------------
    // Constants
    // ------------------------------------------------------------------
    localparam longint unsigned ONE_L   = 64'd1 << FRAC_BITS;
    localparam longint unsigned K048_L  =
        ((64'(K048_NUM) << FRAC_BITS) + 64'(K048_DEN / 2)) / 64'(K048_DEN);
    localparam longint unsigned K0235_L =
        ((64'(K0235_NUM) << FRAC_BITS) + 64'(K0235_DEN / 2)) / 64'(K0235_DEN);
    localparam longint unsigned TINY_L  = (ONE_L + 64'(TINY_DEN / 2)) / 64'(TINY_DEN);
    localparam longint unsigned ST_MAX_L = (64'd1 << ST_W) - 64'd1;

    localparam logic signed [VW-1:0] FX_ONE  = VW'(ONE_L);
    localparam logic signed [VW-1:0] K048    = VW'(K048_L);
    localparam logic signed [VW-1:0] K0235   = VW'(K0235_L);
    localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};

    localparam logic [ST_W-1:0] ST_TINY  = ST_W'(TINY_L);
    localparam logic [ST_W-1:0] ST_RESET = (ONE_L > ST_MAX_L) ? ST_W'(ST_MAX_L) : ST_W'(ONE_L);

    localparam logic [PW-1:0] RND      = PW'(1) << (FRAC_BITS - 1);
    localparam logic [PW-1:0] QMAX_POS = (PW'(1) << (VW - 1)) - PW'(1);
    localparam logic [PW-1:0] QMAX_NEG = PW'(1) << (VW - 1);

    localparam logic [DVD_W-1:0] OM_NUM  = DVD_W'(OMEGA_NUM) << (2 * FRAC_BITS);
    localparam logic [DVD_W-1:0] E_NUM   = DVD_W'(1) << (2 * FRAC_BITS);
    localparam logic [DVD_W-1:0] Q_LIMIT = (DVD_W'(1) << (VW - 1)) - DVD_W'(1);

    localparam logic [1:0] AXIS_FIRST = 2'd0;
    localparam logic [1:0] AXIS_LAST  = 2'd2;

    // multiplier phases
    localparam logic [2:0] PH_LOAD = 3'd0;   // capture magnitudes and sign
    localparam logic [2:0] PH_LO   = 3'd1;   // a * b_lo
    localparam logic [2:0] PH_HI   = 3'd2;   // acc = lo + round, a * b_hi
    localparam logic [2:0] PH_SUM  = 3'd3;   // acc += hi << HW
    localparam logic [2:0] PH_OUT  = 3'd4;   // shift, saturate, write back

    // ------------------------------------------------------------------
    // Sequencer states, one per micro-step
    // ------------------------------------------------------------------
    typedef enum logic [21:0] {
        S_IDLE  = 22'h000001,
        S_OMEGA = 22'h000002,   // omega = 2 / smooth_time
        S_X     = 22'h000004,   // x = omega * dt
        S_X2    = 22'h000008,
        S_X3    = 22'h000010,
        S_DEN1  = 22'h000020,   // den = 1 + x
        S_K048  = 22'h000040,
        S_DEN2  = 22'h000080,
        S_K0235 = 22'h000100,
        S_DEN3  = 22'h000200,
        S_RECIP = 22'h000400,   // e = 1 / den
        S_DIFF  = 22'h000800,   // per axis from here
        S_OD    = 22'h001000,
        S_VT    = 22'h002000,
        S_TEMP  = 22'h004000,
        S_OT    = 22'h008000,
        S_VS    = 22'h010000,
        S_VEL   = 22'h020000,
        S_DT    = 22'h040000,
        S_DE    = 22'h080000,
        S_NEW   = 22'h100000,
        S_OUT   = 22'h200000
    } state_t;

    state_t state_reg, state_next, state_adv;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [ST_W-1:0]        smooth_time_reg;
    logic [2:0]             mph_reg;
    logic                   div_run_reg;
    logic [1:0]             axis_reg;
    logic                   out_valid_reg;
    logic signed [VW-1:0]   vel_reg [3];

    logic signed [DT_W-1:0] dt_reg;
    logic signed [VW-1:0]   pos_reg [3];
    logic signed [VW-1:0]   tgt_reg [3];
    logic signed [VW-1:0]   res_reg [3];
    logic                   upd_reg;

    logic signed [VW-1:0]   omega_reg, x_reg, x2_reg, x3_reg, den_reg, e_reg;
    logic signed [VW-1:0]   diff_reg, temp_reg, t_reg;

    logic [OPW-1:0]         mag_a_reg;
    logic [BW-1:0]          mag_b_reg;
    logic                   neg_reg;
    logic [PPW-1:0]         pp_reg;
    logic [PW-1:0]          acc_reg;

    logic [DVD_W-1:0]       dq_reg;
    logic [DSR_W-1:0]       rem_reg;
    logic [DSR_W-1:0]       dsr_reg;
    logic [CW-1:0]          div_cnt_reg;

    logic signed [VW-1:0]   out_x_reg, out_y_reg, out_z_reg;
    logic                   out_upd_reg;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic in_acc, in_skip, out_free;

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && (state_reg == S_IDLE);
    assign in_skip  = !has_target || time_step[DT_W-1] || (time_step == '0);
    assign out_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign new_x     = out_x_reg;
    assign new_y     = out_y_reg;
    assign new_z     = out_z_reg;
    assign updated   = out_upd_reg;

    // current axis operands
    logic signed [VW-1:0] pos_cur, tgt_cur, vel_cur;

    assign pos_cur = pos_reg[axis_reg];
    assign tgt_cur = tgt_reg[axis_reg];
    assign vel_cur = vel_reg[axis_reg];

    // ------------------------------------------------------------------
    // Sequencer: operand selection and step control
    // ------------------------------------------------------------------
    logic                  is_mul, is_add, is_div, step_done;
    logic                  mul_last, div_fin;
    logic signed [OPW-1:0] mul_sel_a, mul_sel_b;
    logic signed [VW-1:0]  add_a, add_b;
    logic                  add_sub;

    assign mul_last = (mph_reg == PH_OUT);
    assign div_fin  = div_run_reg && (div_cnt_reg == '0);

    always_comb
    begin
        state_adv = state_reg;
        is_mul    = 1'b0;
        is_add    = 1'b0;
        is_div    = 1'b0;
        mul_sel_a = '0;
        mul_sel_b = '0;
        add_a     = '0;
        add_b     = '0;
        add_sub   = 1'b0;
        unique case (state_reg)
            S_IDLE:  state_adv = in_skip ? S_OUT : S_OMEGA;
            S_OMEGA:
            begin
                is_div    = 1'b1;
                state_adv = S_X;
            end
            S_X:
            begin
                is_mul    = 1'b1;
                mul_sel_a = OPW'(omega_reg);
                mul_sel_b = OPW'(dt_reg);
                state_adv = S_X2;
            end
            S_X2:
            begin
                is_mul    = 1'b1;
                mul_sel_a = OPW'(x_reg);
                mul_sel_b = OPW'(x_reg);
                state_adv = S_X3;
            end
            S_X3:
            begin
                is_mul    = 1'b1;
                mul_sel_a = OPW'(x2_reg);
                mul_sel_b = OPW'(x_reg);
                state_adv = S_DEN1;
            end
            S_DEN1:
            begin
                is_add    = 1'b1;
                add_a     = FX_ONE;
                add_b     = x_reg;
                state_adv = S_K048;
            end
            S_K048:
            begin
                is_mul    = 1'b1;
                mul_sel_a = OPW'(K048);
                mul_sel_b = OPW'(x2_reg);
                state_adv = S_DEN2;
            end
            S_DEN2:
            begin
                is_add    = 1'b1;
                add_a     = den_reg;
                add_b     = t_reg;
                state_adv = S_K0235;
            end
            S_K0235:
            begin
                is_mul    = 1'b1;
                mul_sel_a = OPW'(K0235);
                mul_sel_b = OPW'(x3_reg);
                state_adv = S_DEN3;
            end
            S_DEN3:
            begin
                is_add    = 1'b1;
                add_a     = den_reg;
                add_b     = t_reg;
                state_adv = S_RECIP;
            end
            S_RECIP:
            begin
                is_div    = 1'b1;
                state_adv = S_DIFF;
            end
            S_DIFF:
            begin
                is_add    = 1'b1;
                add_a     = pos_cur;
                add_b     = tgt_cur;
                add_sub   = 1'b1;
                state_adv = S_OD;
            end
            S_OD:
            begin
                is_mul    = 1'b1;
                mul_sel_a = OPW'(omega_reg);
                mul_sel_b = OPW'(diff_reg);
                state_adv = S_VT;
            end
            S_VT:
            begin
                is_add    = 1'b1;
                add_a     = vel_cur;
                add_b     = t_reg;
                state_adv = S_TEMP;
            end
            S_TEMP:
            begin
                is_mul    = 1'b1;
                mul_sel_a = OPW'(t_reg);
                mul_sel_b = OPW'(dt_reg);
                state_adv = S_OT;
            end
            S_OT:
            begin
                is_mul    = 1'b1;
                mul_sel_a = OPW'(omega_reg);
                mul_sel_b = OPW'(temp_reg);
                state_adv = S_VS;
            end
            S_VS:
            begin
                is_add    = 1'b1;
                add_a     = vel_cur;
                add_b     = t_reg;
                add_sub   = 1'b1;
                state_adv = S_VEL;
            end
            S_VEL:
            begin
                is_mul    = 1'b1;
                mul_sel_a = OPW'(t_reg);
                mul_sel_b = OPW'(e_reg);
                state_adv = S_DT;
            end
            S_DT:
            begin
                is_add    = 1'b1;
                add_a     = diff_reg;
                add_b     = temp_reg;
                state_adv = S_DE;
            end
            S_DE:
            begin
                is_mul    = 1'b1;
                mul_sel_a = OPW'(t_reg);
                mul_sel_b = OPW'(e_reg);
                state_adv = S_NEW;
            end
            S_NEW:
            begin
                is_add    = 1'b1;
                add_a     = tgt_cur;
                add_b     = t_reg;
                state_adv = (axis_reg == AXIS_LAST) ? S_OUT : S_DIFF;
            end
            S_OUT:   state_adv = S_IDLE;
            default: state_adv = S_IDLE;
        endcase

        if (state_reg == S_IDLE)
            step_done = in_acc;
        else if (state_reg == S_OUT)
            step_done = out_free;
        else if (is_mul)
            step_done = mul_last;
        else if (is_div)
            step_done = div_fin;
        else
            step_done = is_add;

        state_next = step_done ? state_adv : state_reg;
    end

    // ------------------------------------------------------------------
    // Shared saturating adder
    // ------------------------------------------------------------------
    logic signed [VW:0]   add_sum;
    logic signed [VW-1:0] add_res;

    assign add_sum = add_sub ? ({add_a[VW-1], add_a} - {add_b[VW-1], add_b})
                             : ({add_a[VW-1], add_a} + {add_b[VW-1], add_b});
    assign add_res = (add_sum[VW] != add_sum[VW-1]) ? (add_sum[VW] ? VAL_MIN : VAL_MAX)
                                                     : add_sum[VW-1:0];

    // ------------------------------------------------------------------
    // Shared multiplier: sign-magnitude, two half passes, round half away
    // ------------------------------------------------------------------
    logic [OPW-1:0]       mag_a_c, mag_b_c;
    logic [PW-1:0]        mul_q;
    logic signed [VW-1:0] mul_res;

    assign mag_a_c = mul_sel_a[OPW-1] ? $unsigned(-mul_sel_a) : $unsigned(mul_sel_a);
    assign mag_b_c = mul_sel_b[OPW-1] ? $unsigned(-mul_sel_b) : $unsigned(mul_sel_b);
    assign mul_q   = acc_reg >> FRAC_BITS;

    always_comb
    begin
        if (neg_reg)
            mul_res = (mul_q > QMAX_NEG) ? VAL_MIN : -mul_q[VW-1:0];
        else
            mul_res = (mul_q > QMAX_POS) ? VAL_MAX : mul_q[VW-1:0];
    end

    // ------------------------------------------------------------------
    // Shared divider: restoring, one quotient bit a cycle
    // ------------------------------------------------------------------
    logic [ST_W-1:0]      st_eff;
    logic [VW-1:0]        den_u;
    logic [DVD_W-1:0]     div_dvd_c;
    logic [DSR_W-1:0]     div_dsr_c;
    logic [DSR_W:0]       div_trial;
    logic                 div_ge;
    logic [DSR_W-1:0]     div_rem_c;
    logic signed [VW-1:0] div_q_sat;

    assign st_eff    = (smooth_time_reg == '0) ? ST_TINY : smooth_time_reg;
    assign den_u     = $unsigned(den_reg);
    assign div_dvd_c = (state_reg == S_OMEGA) ? OM_NUM + DVD_W'(st_eff >> 1)
                                              : E_NUM + DVD_W'(den_u >> 1);
    assign div_dsr_c = (state_reg == S_OMEGA) ? DSR_W'(st_eff) : DSR_W'(den_u);

    assign div_trial = {rem_reg, dq_reg[DVD_W-1]};
    assign div_ge    = (div_trial >= {1'b0, dsr_reg});
    assign div_rem_c = div_ge ? DSR_W'(div_trial - {1'b0, dsr_reg}) : div_trial[DSR_W-1:0];
    assign div_q_sat = (dq_reg > Q_LIMIT) ? VAL_MAX : $signed(dq_reg[VW-1:0]);

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            smooth_time_reg <= ST_RESET;
            mph_reg         <= PH_LOAD;
            div_run_reg     <= 1'b0;
            axis_reg        <= AXIS_FIRST;
            out_valid_reg   <= 1'b0;
            vel_reg[0]      <= '0;
            vel_reg[1]      <= '0;
            vel_reg[2]      <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
                smooth_time_reg <= cfg_wr_data;

            if (is_mul)
                mph_reg <= mul_last ? PH_LOAD : mph_reg + 3'd1;

            if (is_div)
            begin
                if (!div_run_reg)
                    div_run_reg <= 1'b1;
                else if (div_fin)
                    div_run_reg <= 1'b0;
            end

            if (in_acc)
                axis_reg <= AXIS_FIRST;
            else if ((state_reg == S_NEW) && (axis_reg != AXIS_LAST))
                axis_reg <= axis_reg + 2'd1;

            if ((state_reg == S_VEL) && mul_last)
                vel_reg[axis_reg] <= mul_res;

            if ((state_reg == S_OUT) && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        // capture a transaction; pass-through result is the position itself
        if (in_acc)
        begin
            dt_reg     <= time_step;
            pos_reg[0] <= pos_x;
            pos_reg[1] <= pos_y;
            pos_reg[2] <= pos_z;
            tgt_reg[0] <= target_x;
            tgt_reg[1] <= target_y;
            tgt_reg[2] <= target_z;
            res_reg[0] <= pos_x;
            res_reg[1] <= pos_y;
            res_reg[2] <= pos_z;
            upd_reg    <= !in_skip;
        end

        // multiplier pipeline
        if (is_mul)
        begin
            case (mph_reg)
                PH_LOAD:
                begin
                    mag_a_reg <= mag_a_c;
                    mag_b_reg <= BW'(mag_b_c);
                    neg_reg   <= mul_sel_a[OPW-1] ^ mul_sel_b[OPW-1];
                end
                PH_LO:   pp_reg <= PPW'(mag_a_reg) * PPW'(mag_b_reg[HW-1:0]);
                PH_HI:
                begin
                    acc_reg <= PW'(pp_reg) + RND;
                    pp_reg  <= PPW'(mag_a_reg) * PPW'(mag_b_reg[BW-1:HW]);
                end
                PH_SUM:  acc_reg <= acc_reg + (PW'(pp_reg) << HW);
                default: ;
            endcase
        end

        if (is_mul && mul_last)
        begin
            case (state_reg) inside
                S_X:                               x_reg    <= mul_res;
                S_X2:                              x2_reg   <= mul_res;
                S_X3:                              x3_reg   <= mul_res;
                S_TEMP:                            temp_reg <= mul_res;
                S_K048, S_K0235, S_OD, S_OT, S_DE: t_reg    <= mul_res;
                default: ;
            endcase
        end

        // adder write-back
        if (is_add)
        begin
            case (state_reg) inside
                S_DEN1, S_DEN2, S_DEN3: den_reg           <= add_res;
                S_DIFF:                 diff_reg          <= add_res;
                S_VT, S_VS, S_DT:       t_reg             <= add_res;
                S_NEW:                  res_reg[axis_reg] <= add_res;
                default: ;
            endcase
        end

        // divider
        if (is_div)
        begin
            if (!div_run_reg)
            begin
                dq_reg      <= div_dvd_c;
                dsr_reg     <= div_dsr_c;
                rem_reg     <= '0;
                div_cnt_reg <= CW'(DVD_W);
            end
            else if (!div_fin)
            begin
                rem_reg     <= div_rem_c;
                dq_reg      <= {dq_reg[DVD_W-2:0], div_ge};
                div_cnt_reg <= div_cnt_reg - CW'(1);
            end
            else if (state_reg == S_OMEGA)
                omega_reg <= div_q_sat;
            else
                e_reg <= div_q_sat;
        end

        // output register
        if ((state_reg == S_OUT) && out_free)
        begin
            out_x_reg   <= res_reg[0];
            out_y_reg   <= res_reg[1];
            out_z_reg   <= res_reg[2];
            out_upd_reg <= upd_reg;
        end
    end

endmodule
